// ===== rtl/fat12_pkg.sv =====
`default_nettype none

package fat12_pkg;

  // Field widths of the item and result beats.
  localparam int ModeW    = 3;
  localparam int ClusterW = 8;
  localparam int EntryW   = 12;
  localparam int CountW   = 8;
  localparam int StatusW  = 2;

  // Default table size and reset value of the last cluster register.
  localparam int TableEntriesDef = 256;
  localparam logic [ClusterW-1:0] LastClusterReset = 8'd237;

  // Special entry values.
  localparam logic [EntryW-1:0] MarkEoc   = 12'hFFF;
  localparam logic [EntryW-1:0] MarkBad   = 12'hFF7;
  localparam logic [EntryW-1:0] EocLow    = 12'hFF8;
  localparam logic [EntryW-1:0] MarkMedia = 12'hFF9;
  localparam logic [EntryW-1:0] EntryFree = 12'h000;

  // Operation codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    ModeRead      = 3'd0,
    ModeWrite     = 3'd1,
    ModeAlloc     = 3'd2,
    ModeFree      = 3'd3,
    ModeCount     = 3'd4,
    ModeCountFree = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusNoSpace = 2'd1,
    StatusCorrupt = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/fat12_cluster_chain_engine.sv =====
`default_nettype none

// Cluster allocation table engine: one 12-bit entry per cluster, held in a single-port-write,
// single-port-read synchronous RAM, with one operation per input beat chosen by mode (read,
// write, allocate chain, free chain, count chain, count free) and exactly one result beat per
// input beat. After reset the engine loads the first min(TABLE_ENTRIES, 256) RAM entries
// with their initial contents and accepts no input beat during that time; writes to
// last_cluster are taken at any time but should only be made while the engine is idle.
// Count free scans clusters 2 to the last cluster at one RAM read per cycle; allocate scans
// the same way and stops once its chain is complete. An allocation that fails after taking
// clusters then walks the partial chain again, one entry per cycle. Free chain and count
// chain follow the links at one RAM read per cycle. Only the first 256 entries are
// reachable, since cluster numbers are 8 bits wide.
module fat12_cluster_chain_engine
  import fat12_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration
  input  wire logic                cfg_we_i,
  input  wire logic [ClusterW-1:0] cfg_wdata_i,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ModeW-1:0]    mode_i,
  input  wire logic [ClusterW-1:0] cluster_i,
  input  wire logic [EntryW-1:0]   entry_value_i,
  input  wire logic [ClusterW-1:0] want_clusters_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [StatusW-1:0]       status_o,
  output logic [EntryW-1:0]        result_value_o,
  output logic [CountW-1:0]        result_count_o
);

  localparam int Reach = 2 ** ClusterW;
  localparam int Depth = (TABLE_ENTRIES < Reach) ? TABLE_ENTRIES : Reach;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0]       LastIdx = AW'(Depth - 1);
  localparam logic [ClusterW-1:0] MaxLast = ClusterW'(Depth - 1);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRdData,
    StScanFree,
    StAlloc,
    StAllocEoc,
    StFreeIssue,
    StFreeData,
    StCntData,
    StDone
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]       clr_q, clr_d;
  logic [ClusterW-1:0] last_q;
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [EntryW-1:0]   value_q, value_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [EntryW-1:0]   res_value_q, res_value_d;
  logic [CountW-1:0]   res_count_q, res_count_d;
  logic                in_range_q, in_range_d;
  logic [ClusterW-1:0] want_q, want_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [ClusterW-1:0] prev_q, prev_d;
  logic [ClusterW-1:0] first_q, first_d;
  logic [ClusterW-1:0] dat_addr_q, dat_addr_d;
  logic [ClusterW:0]   scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [ClusterW-1:0] c_q, c_d;

  // Table RAM and its read forwarding path.
  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;
  logic              fwd_q;
  logic [EntryW-1:0] fwd_data_q;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [EntryW-1:0] wdata;

  logic                accept;
  logic                in_range;
  logic                cl_valid;
  logic [ClusterW-1:0] eff_last;
  logic [ClusterW:0]   last9;
  logic [EntryW-1:0]   nxt;
  logic                nxt_end;
  logic                nxt_valid;
  logic                issue;
  logic [CountW-1:0]   cnt_inc;
  logic [CountW:0]     cnt_inc9;

  // Effective last cluster, limited by the table size.
  assign eff_last = (last_q > MaxLast) ? MaxLast : last_q;
  assign last9    = {1'b0, eff_last};

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(cluster_i) < TABLE_ENTRIES);
  assign cl_valid   = (cluster_i >= ClusterW'(2)) && (cluster_i <= eff_last);

  // The entry read in the previous cycle, with a same-cycle write forwarded.
  assign nxt       = fwd_q ? fwd_data_q : rdata_q;
  assign nxt_end   = (nxt >= EocLow);
  assign nxt_valid = (nxt >= EntryW'(2)) && (nxt <= {{(EntryW - ClusterW){1'b0}}, eff_last});
  assign issue     = (scan_q <= last9);
  assign cnt_inc   = cnt_q + CountW'(1);
  assign cnt_inc9  = {1'b0, cnt_q} + (CountW + 1)'(1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    value_d      = value_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_count_d  = res_count_q;
    in_range_d   = in_range_q;
    want_d       = want_q;
    cnt_d        = cnt_q;
    prev_d       = prev_q;
    first_d      = first_q;
    dat_addr_d   = dat_addr_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    c_d          = c_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = cluster_i[AW-1:0];

    // The output register empties when its beat is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == AW'(0)) begin
          wdata = MarkMedia;
        end else if (clr_q == AW'(1)) begin
          wdata = MarkEoc;
        end else begin
          wdata = EntryFree;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == LastIdx) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (accept) begin
          res_status_d = StatusOk;
          res_value_d  = '0;
          res_count_d  = '0;
          case (mode_e'(mode_i))
            ModeRead: begin
              in_range_d = in_range;
              state_d    = StRdData;
            end
            ModeWrite: begin
              we      = in_range;
              waddr   = cluster_i[AW-1:0];
              wdata   = entry_value_i;
              state_d = StDone;
            end
            ModeAlloc: begin
              want_d  = want_clusters_i;
              cnt_d   = '0;
              scan_d  = (ClusterW + 1)'(2);
              pend_d  = 1'b0;
              state_d = (want_clusters_i == '0) ? StDone : StAlloc;
            end
            ModeFree: begin
              c_d     = cluster_i;
              cnt_d   = '0;
              state_d = cl_valid ? StFreeData : StDone;
            end
            ModeCount: begin
              cnt_d = CountW'(1);
              if (cluster_i == '0) begin
                state_d = StDone;
              end else if (!cl_valid) begin
                res_status_d = StatusCorrupt;
                state_d      = StDone;
              end else begin
                state_d = StCntData;
              end
            end
            ModeCountFree: begin
              cnt_d   = '0;
              scan_d  = (ClusterW + 1)'(2);
              pend_d  = 1'b0;
              state_d = StScanFree;
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end

      StRdData: begin
        res_value_d = in_range_q ? nxt : '0;
        state_d     = StDone;
      end

      // Scan clusters two to the last cluster and count the free ones.
      StScanFree: begin
        raddr      = scan_q[AW-1:0];
        pend_d     = issue;
        dat_addr_d = scan_q[ClusterW-1:0];
        if (issue) begin
          scan_d = scan_q + (ClusterW + 1)'(1);
        end
        if (pend_q && (nxt == EntryFree)) begin
          cnt_d = cnt_inc;
        end
        if (!issue && !pend_q) begin
          res_count_d = cnt_q;
          state_d     = StDone;
        end
      end

      // First-fit scan. Each hit links the previous cluster to this one; the tail
      // gets its end mark once the chain is complete.
      StAlloc: begin
        raddr      = scan_q[AW-1:0];
        pend_d     = issue;
        dat_addr_d = scan_q[ClusterW-1:0];
        if (issue) begin
          scan_d = scan_q + (ClusterW + 1)'(1);
        end
        if (pend_q && (nxt == EntryFree)) begin
          if (cnt_q != '0) begin
            we    = 1'b1;
            waddr = prev_q[AW-1:0];
            wdata = {{(EntryW - ClusterW){1'b0}}, dat_addr_q};
          end else begin
            first_d = dat_addr_q;
          end
          prev_d = dat_addr_q;
          cnt_d  = cnt_inc;
          if (cnt_inc == want_q) begin
            pend_d  = 1'b0;
            state_d = StAllocEoc;
          end
        end else if (!issue && !pend_q) begin
          // Not enough free clusters: release what was taken.
          res_status_d = StatusNoSpace;
          c_d          = first_q;
          cnt_d        = '0;
          state_d      = (cnt_q == '0) ? StDone : StFreeIssue;
        end
      end

      StAllocEoc: begin
        we          = 1'b1;
        waddr       = prev_q[AW-1:0];
        wdata       = MarkEoc;
        res_value_d = {{(EntryW - ClusterW){1'b0}}, first_q};
        state_d     = StDone;
      end

      StFreeIssue: begin
        raddr   = c_q[AW-1:0];
        state_d = StFreeData;
      end

      // Clear the current link and follow it while it points to a valid cluster.
      StFreeData: begin
        we    = 1'b1;
        waddr = c_q[AW-1:0];
        wdata = EntryFree;
        if (nxt_end || !nxt_valid || (cnt_inc9 >= last9)) begin
          state_d = StDone;
        end else begin
          c_d   = nxt[ClusterW-1:0];
          cnt_d = cnt_inc;
          raddr = nxt[AW-1:0];
        end
      end

      // Follow the chain and count its clusters, checking every link.
      StCntData: begin
        if ((nxt == EntryFree) || (nxt == MarkBad)) begin
          res_status_d = StatusCorrupt;
          state_d      = StDone;
        end else if (nxt_end) begin
          res_count_d = cnt_q;
          state_d     = StDone;
        end else if (!nxt_valid || (cnt_inc9 >= last9)) begin
          res_status_d = StatusCorrupt;
          state_d      = StDone;
        end else begin
          cnt_d = cnt_inc;
          raddr = nxt[AW-1:0];
        end
      end

      // Hand the result to the output register once it is free.
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          value_d     = res_value_q;
          count_d     = res_count_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer state, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      last_q       <= LastClusterReset;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      value_q      <= '0;
      count_q      <= '0;
      res_status_q <= '0;
      res_value_q  <= '0;
      res_count_q  <= '0;
      in_range_q   <= 1'b0;
      want_q       <= '0;
      cnt_q        <= '0;
      prev_q       <= '0;
      first_q      <= '0;
      dat_addr_q   <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      c_q          <= '0;
      fwd_q        <= 1'b0;
      fwd_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      if (cfg_we_i) begin
        last_q <= cfg_wdata_i;
      end
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      value_q      <= value_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_count_q  <= res_count_d;
      in_range_q   <= in_range_d;
      want_q       <= want_d;
      cnt_q        <= cnt_d;
      prev_q       <= prev_d;
      first_q      <= first_d;
      dat_addr_q   <= dat_addr_d;
      scan_q       <= scan_d;
      pend_q       <= pend_d;
      c_q          <= c_d;
      fwd_q        <= we && (waddr == raddr);
      fwd_data_q   <= wdata;
    end
  end

  // Table RAM: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = value_q;
  assign result_count_o = count_q;

endmodule

`default_nettype wire

// ===== dv/fat12_cluster_chain_engine_test.sv =====
`timescale 1ns / 1ps

module fat12_cluster_chain_engine_test;
  import fat12_pkg::*;

  // Mode codes that the block leaves unused.
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 225;
  localparam int NumPhases  = 8;

  typedef enum int {
    RxAlways,
    RxChoppy,
    RxLongStalls
  } rx_style_e;

  typedef struct {
    logic [ModeW-1:0]    mode;
    logic [ClusterW-1:0] cluster;
    logic [EntryW-1:0]   value;
    logic [ClusterW-1:0] want;
  } fat_req_t;

  typedef struct {
    status_e           status;
    logic [EntryW-1:0] value;
    logic [CountW-1:0] count;
  } fat_res_t;

  // Shadow allocation table that predicts every result beat and checks it.
  class fat_table_tracker;
    logic [EntryW-1:0] fat [TableEntriesDef];
    int unsigned       last_cl;
    fat_res_t          owed[$];
    int unsigned       errors;
    int unsigned       n_items;
    int unsigned       n_granted;
    int unsigned       n_refused;
    int unsigned       n_corrupt;

    function new();
      foreach (fat[i]) fat[i] = EntryFree;
      fat[0]  = MarkMedia;
      fat[1]  = MarkEoc;
      last_cl = 32'(LastClusterReset);
    endfunction

    function bit is_link(int unsigned c);
      return c >= 2 && c <= last_cl;
    endfunction

    function bit is_eoc(int unsigned v);
      return v >= EocLow && v <= MarkEoc;
    endfunction

    // Clear a chain link by link, with a guard against loops.
    function void release_chain(int unsigned start);
      int unsigned c, steps, nxt;
      c = start;
      steps = 0;
      if (!is_link(start)) return;
      while (is_link(c) && steps <= last_cl - 1) begin
        nxt = 32'(fat[c]);
        fat[c] = EntryFree;
        if (is_eoc(nxt) || !is_link(nxt)) return;
        c = nxt;
        steps++;
      end
    endfunction

    // First-fit allocation; a short chain is handed back on failure.
    function status_e take_chain(int unsigned want, output int unsigned first);
      int unsigned prev, made;
      first = 0;
      prev = 0;
      made = 0;
      if (want == 0) return StatusOk;
      for (int unsigned c = 2; c <= last_cl && made < want; c++) begin
        if (fat[c] == EntryFree) begin
          if (first == 0) first = c;
          if (prev != 0) fat[prev] = c[EntryW-1:0];
          fat[c] = MarkEoc;
          prev = c;
          made++;
        end
      end
      if (made != want) begin
        if (first != 0) release_chain(first);
        first = 0;
        return StatusNoSpace;
      end
      return StatusOk;
    endfunction

    function status_e measure_chain(int unsigned start, output int unsigned len);
      int unsigned c, n, nxt;
      len = 0;
      c = start;
      n = 0;
      if (start == 0) return StatusOk;
      if (!is_link(start)) return StatusCorrupt;
      while (is_link(c)) begin
        n++;
        if (n > last_cl - 1) return StatusCorrupt;
        nxt = 32'(fat[c]);
        if (nxt == EntryFree || nxt == MarkBad) return StatusCorrupt;
        if (is_eoc(nxt)) begin
          len = n;
          return StatusOk;
        end
        if (!is_link(nxt)) return StatusCorrupt;
        c = nxt;
      end
      return StatusCorrupt;
    endfunction

    function int unsigned count_free();
      int unsigned n;
      n = 0;
      for (int unsigned c = 2; c <= last_cl; c++) begin
        if (fat[c] == EntryFree) n++;
      end
      return n;
    endfunction

    // Apply an accepted request beat and queue the result it must produce.
    function fat_res_t accept_request(fat_req_t r);
      fat_res_t    res;
      int unsigned first, n;
      res.status = StatusOk;
      res.value  = '0;
      res.count  = '0;
      case (r.mode)
        ModeRead: res.value = fat[r.cluster];
        ModeWrite: fat[r.cluster] = r.value;
        ModeAlloc: begin
          res.status = take_chain(r.want, first);
          res.value  = first[EntryW-1:0];
        end
        ModeFree: release_chain(r.cluster);
        ModeCount: begin
          res.status = measure_chain(r.cluster, n);
          res.count  = n[CountW-1:0];
        end
        ModeCountFree: begin
          n = count_free();
          res.count = n[CountW-1:0];
        end
        default: ;
      endcase
      n_items++;
      if (r.mode == ModeAlloc && res.status == StatusOk && res.value != 0) n_granted++;
      if (res.status == StatusNoSpace) n_refused++;
      if (res.status == StatusCorrupt) n_corrupt++;
      owed.push_back(res);
      return res;
    endfunction

    function void check_beat(logic [StatusW-1:0] st, logic [EntryW-1:0] v,
                             logic [CountW-1:0] cnt);
      fat_res_t exp_res;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d value %0d count %0d",
               st, v, cnt);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (st !== exp_res.status) begin
        $error("status mismatch: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (v !== exp_res.value) begin
        $error("result_value mismatch: expected %0d, got %0d", exp_res.value, v);
        errors++;
      end
      if (cnt !== exp_res.count) begin
        $error("result_count mismatch: expected %0d, got %0d", exp_res.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [ClusterW-1:0] cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode_i          = '0;
  logic [ClusterW-1:0] cluster_i       = '0;
  logic [EntryW-1:0]   entry_value_i   = '0;
  logic [ClusterW-1:0] want_clusters_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [EntryW-1:0]   result_value_o;
  logic [CountW-1:0]   result_count_o;

  fat_table_tracker sb;
  int unsigned      live_heads[$];
  rx_style_e        rx_style   = RxAlways;
  bit               gaps_on    = 1'b0;
  int unsigned      burst_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      quiet      = 0;

  fat12_cluster_chain_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .cluster_i       (cluster_i),
    .entry_value_i   (entry_value_i),
    .want_clusters_i (want_clusters_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_value_o  (result_value_o),
    .result_count_o  (result_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Receiver back-pressure, shaped by the current style.
  always @(posedge clk_i) begin : rx_pattern
    bit rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else if (rx_style == RxChoppy) begin
      rdy = ($urandom_range(0, 2) != 0);
    end else if (rx_style == RxLongStalls && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 30);
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      sb.check_beat(status_o, result_value_o, result_count_o);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("fat12_cluster_chain_engine_test: errors");
      $finish;
    end
  end

  function automatic fat_req_t mk_req(logic [ModeW-1:0] mode, int unsigned cl,
                                      int unsigned val, int unsigned want);
    fat_req_t r;
    r.mode    = mode;
    r.cluster = cl[ClusterW-1:0];
    r.value   = val[EntryW-1:0];
    r.want    = want[ClusterW-1:0];
    return r;
  endfunction

  // Present one request beat, honoring the burst and gap pattern.
  task automatic send_req(input fat_req_t r);
    fat_res_t    res;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    mode_i          <= r.mode;
    cluster_i       <= r.cluster;
    entry_value_i   <= r.value;
    want_clusters_i <= r.want;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    res = sb.accept_request(r);
    if (r.mode == ModeAlloc && res.status == StatusOk && res.value != 0) begin
      live_heads.push_back(32'(res.value));
    end
  endtask

  task automatic drain_to_idle();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_last_cluster(input int unsigned lc);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lc[ClusterW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.last_cl = lc;
  endtask

  // Mostly well-formed chain traffic around live chains, plus corruption and noise.
  function automatic fat_req_t pick_request();
    fat_req_t    r;
    int unsigned roll, lc, idx, kind;
    lc = sb.last_cl;
    r = mk_req(ModeRead, $urandom_range(0, 255), $urandom_range(0, 4095),
               $urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (live_heads.size() == 0 && roll < 60) roll = 0;
    if (live_heads.size() > 0 && sb.count_free() < lc / 4 + 1 && roll < 50) roll = 50;

    if (roll < 30) begin
      r.mode = ModeAlloc;
      if ($urandom_range(0, 9) != 0) r.want = ClusterW'($urandom_range(1, lc < 8 ? lc : 8));
    end else if (roll < 45) begin
      r.mode = ModeCount;
      if (live_heads.size() > 0) begin
        r.cluster = ClusterW'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
      end
    end else if (roll < 57) begin
      r.mode = ModeFree;
      if (live_heads.size() > 0) begin
        idx = $urandom_range(0, live_heads.size() - 1);
        r.cluster = ClusterW'(live_heads[idx]);
        live_heads.delete(idx);
      end
    end else if (roll < 65) begin
      r.mode = ModeCountFree;
    end else if (roll < 72) begin
      if (live_heads.size() > 0 && $urandom_range(0, 1) == 1) begin
        r.cluster = ClusterW'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
      end
    end else if (roll < 84) begin
      r.mode = ModeWrite;
      if (live_heads.size() > 0 && $urandom_range(0, 2) == 0) begin
        r.cluster = ClusterW'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
      end else if ($urandom_range(0, 1) == 1) begin
        r.cluster = ClusterW'($urandom_range(2, lc));
      end
      kind = $urandom_range(0, 5);
      case (kind)
        0: r.value = EntryFree;
        1: r.value = MarkBad;
        2: r.value = EntryW'($urandom_range(EocLow, MarkEoc));
        3: r.value = EntryW'($urandom_range(2, lc));
        default: ;
      endcase
    end else if (roll < 90) begin
      r.mode = ModeCount;
    end else if (roll < 95) begin
      r.mode = ModeFree;
    end else begin
      r.mode = $urandom_range(0, 1) ? ModeSpareHi : ModeSpareLo;
    end
    return r;
  endfunction

  initial begin : main_seq
    int unsigned phase_last [NumPhases];
    int unsigned lc;
    phase_last = '{255, 2, 3, 0, 16, 0, 128, 237};
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at the reset value of last_cluster on a fresh table.
    send_req(mk_req(ModeRead, 0, 0, 0));
    send_req(mk_req(ModeRead, 1, 0, 0));
    send_req(mk_req(ModeRead, 255, 0, 0));
    send_req(mk_req(ModeCountFree, 0, 0, 0));
    send_req(mk_req(ModeCount, 0, 0, 0));
    send_req(mk_req(ModeCount, 1, 0, 0));
    send_req(mk_req(ModeCount, 255, 0, 0));
    send_req(mk_req(ModeCount, 2, 0, 0));
    send_req(mk_req(ModeAlloc, 0, 0, 0));
    send_req(mk_req(ModeAlloc, 0, 0, 3));
    send_req(mk_req(ModeCount, 2, 0, 0));
    send_req(mk_req(ModeAlloc, 0, 0, 1));
    // A chain that runs into a bad cluster.
    send_req(mk_req(ModeWrite, 5, 6, 0));
    send_req(mk_req(ModeWrite, 6, MarkBad, 0));
    send_req(mk_req(ModeCount, 5, 0, 0));
    // A cluster that links to itself.
    send_req(mk_req(ModeWrite, 7, 7, 0));
    send_req(mk_req(ModeCount, 7, 0, 0));
    send_req(mk_req(ModeFree, 7, 0, 0));
    send_req(mk_req(ModeAlloc, 0, 0, 255));
    send_req(mk_req(ModeFree, 2, 0, 0));
    send_req(mk_req(ModeFree, 0, 0, 0));
    send_req(mk_req(ModeSpareLo, 255, 4095, 255));
    send_req(mk_req(ModeSpareHi, 255, 4095, 255));
    send_req(mk_req(ModeWrite, 0, EntryFree, 0));
    send_req(mk_req(ModeRead, 0, 0, 0));
    live_heads.delete();
    drain_to_idle();

    // Random phases, each with its own last_cluster and traffic shape.
    for (int p = 0; p < NumPhases; p++) begin
      while (live_heads.size() > 0) begin
        send_req(mk_req(ModeFree, live_heads.pop_front(), $urandom_range(0, 4095), 0));
      end
      drain_to_idle();
      lc = (phase_last[p] == 0) ? $urandom_range(4, 254) : phase_last[p];
      write_last_cluster(lc);
      rx_style = rx_style_e'(p % 3);
      gaps_on  = (p % 4 != 1);
      if (lc <= 16) begin
        for (int unsigned c = 2; c <= lc; c++) send_req(mk_req(ModeWrite, c, EntryFree, 0));
      end
      repeat (PhaseItems) send_req(pick_request());
    end

    drain_to_idle();
    repeat (20) @(posedge clk_i);
    if (sb.owed.size() != 0) begin
      $error("%0d result beats never arrived", sb.owed.size());
      sb.errors++;
    end
    $display("Covered %0d request beats over %0d last_cluster settings and all six modes.",
             sb.n_items, NumPhases + 1);
    $display("Allocations granted %0d, refused for space %0d, chains reported corrupt %0d.",
             sb.n_granted, sb.n_refused, sb.n_corrupt);
    if (sb.errors == 0) begin
      $display("fat12_cluster_chain_engine_test: clean");
    end else begin
      $display("fat12_cluster_chain_engine_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fat12_pkg.sv
rtl/fat12_cluster_chain_engine.sv
dv/fat12_cluster_chain_engine_test.sv
